[hw/rtl/apc_pkg.sv]
// ----------------------------------------------------------------------------
// apc_pkg: shared types and constants for the amicable pair checker
// Payload structs, controller-to-datapath command and status bundles, widths.
// ----------------------------------------------------------------------------
package apc_pkg;

   // Width at which the numbers are evaluated; upper field bits are dropped.
   localparam int DATA_WIDTH    = 16;
   localparam int FIELD_WIDTH   = 16;
   localparam int SUM_WIDTH     = 18;
   localparam int SUM_MAX       = (1 << SUM_WIDTH) - 1;
   // A proper divisor sum stays below eight times the number in this range.
   localparam int ACC_WIDTH     = (DATA_WIDTH + 3 > SUM_WIDTH) ? DATA_WIDTH + 3 : SUM_WIDTH;
   localparam int DIV_CNT_WIDTH = (DATA_WIDTH > 2) ? $clog2(DATA_WIDTH) : 1;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] first_number;
      logic [FIELD_WIDTH-1:0] second_number;
   } req_payload_type;

   typedef struct packed {
      logic                 is_amicable;
      logic [SUM_WIDTH-1:0] first_divisor_sum;
      logic [SUM_WIDTH-1:0] second_divisor_sum;
   } rsp_payload_type;

   typedef struct packed {
      logic load;         // capture a new request, start with the first number
      logic div_start;    // launch one trial division
      logic accum;        // fold the finished trial into the sum, advance candidate
      logic next_number;  // switch to the second number
      logic publish;      // load the result register
   } apc_cmd_type;

   typedef struct packed {
      logic div_done;     // trial division finished this cycle
      logic loop_end;     // candidate exceeds its quotient: number is finished
      logic last_number;  // working on the second number
      logic out_full;     // result register still holds an untaken result
   } apc_sts_type;

endpackage

[hw/rtl/apc_divider.sv]
// ----------------------------------------------------------------------------
// apc_divider: iterative restoring divider
// One quotient bit per cycle; quotient and remainder after DATA_WIDTH steps.
// ----------------------------------------------------------------------------
module apc_divider
   import apc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);

   logic [DATA_WIDTH:0]      rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_WIDTH-1:0] count_ff, count_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DATA_WIDTH:0]      trial;
   logic                     fits;

   always_comb begin
      trial = {rem_ff[DATA_WIDTH-1:0], quo_ff[DATA_WIDTH-1]};
      fits  = (trial >= {1'b0, divisor});
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         count_in = DIV_CNT_WIDTH'(DATA_WIDTH - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? (trial - {1'b0, divisor}) : trial;
         quo_in   = {quo_ff[DATA_WIDTH-2:0], fits};
         count_in = count_ff - DIV_CNT_WIDTH'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      count_ff <= count_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[DATA_WIDTH-1:0];

endmodule

[hw/rtl/apc_datapath.sv]
// ----------------------------------------------------------------------------
// apc_datapath: operand, candidate and sum registers of the pair checker
// Runs trial divisions, accumulates divisor pairs, holds the result register.
// ----------------------------------------------------------------------------
module apc_datapath
   import apc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  apc_cmd_type     cmd,
   output apc_sts_type     sts,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [DATA_WIDTH-1:0] num_a_ff, num_a_in;
   logic [DATA_WIDTH-1:0] num_b_ff, num_b_in;
   logic [DATA_WIDTH-1:0] cand_ff, cand_in;
   logic [ACC_WIDTH-1:0]  sum_a_ff, sum_a_in;
   logic [ACC_WIDTH-1:0]  sum_b_ff, sum_b_in;
   logic                  sel_ff, sel_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [DATA_WIDTH-1:0] cur_num;
   logic [DATA_WIDTH-1:0] quo;
   logic [DATA_WIDTH-1:0] rem;
   logic                  div_done;
   logic [ACC_WIDTH-1:0]  add_low;
   logic [ACC_WIDTH-1:0]  add_high;
   logic [ACC_WIDTH-1:0]  sum_cur;
   logic [ACC_WIDTH-1:0]  sum_next;

   assign cur_num = sel_ff ? num_b_ff : num_a_ff;

   apc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (cur_num),
      .divisor   (cand_ff),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   function automatic logic [SUM_WIDTH-1:0] clip_sum(input logic [ACC_WIDTH-1:0] s);
      logic [SUM_WIDTH-1:0] r;
      r = (s > ACC_WIDTH'(SUM_MAX)) ? SUM_WIDTH'(SUM_MAX) : s[SUM_WIDTH-1:0];
      return r;
   endfunction

   always_comb begin
      // Divisor d and its partner n/d; skip n itself, count a square root once.
      add_low  = (rem == '0 && cand_ff != cur_num) ? ACC_WIDTH'(cand_ff) : '0;
      add_high = (rem == '0 && quo != cand_ff && quo != cur_num) ? ACC_WIDTH'(quo) : '0;
      sum_cur  = sel_ff ? sum_b_ff : sum_a_ff;
      sum_next = sum_cur + add_low + add_high;

      num_a_in = num_a_ff;
      num_b_in = num_b_ff;
      cand_in  = cand_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      sel_in   = sel_ff;
      if (cmd.load) begin
         num_a_in = DATA_WIDTH'(req_payload.first_number);
         num_b_in = DATA_WIDTH'(req_payload.second_number);
         cand_in  = DATA_WIDTH'(1);
         sum_a_in = '0;
         sum_b_in = '0;
         sel_in   = 1'b0;
      end else if (cmd.accum) begin
         cand_in = cand_ff + DATA_WIDTH'(1);
         if (sel_ff) begin
            sum_b_in = sum_next;
         end else begin
            sum_a_in = sum_next;
         end
      end else if (cmd.next_number) begin
         cand_in = DATA_WIDTH'(1);
         sel_in  = 1'b1;
      end

      rsp_data_in = rsp_data_ff;
      if (cmd.publish) begin
         rsp_data_in.is_amicable        = (sum_a_ff == ACC_WIDTH'(num_b_ff)) &&
                                          (sum_b_ff == ACC_WIDTH'(num_a_ff));
         rsp_data_in.first_divisor_sum  = clip_sum(sum_a_ff);
         rsp_data_in.second_divisor_sum = clip_sum(sum_b_ff);
      end
      rsp_valid_in = cmd.publish | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      num_a_ff    <= num_a_in;
      num_b_ff    <= num_b_in;
      cand_ff     <= cand_in;
      sum_a_ff    <= sum_a_in;
      sum_b_ff    <= sum_b_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      sts.div_done    = div_done;
      sts.loop_end    = (cand_ff > quo);
      sts.last_number = sel_ff;
      sts.out_full    = rsp_valid_ff;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

[hw/rtl/apc_ctrl.sv]
// ----------------------------------------------------------------------------
// apc_ctrl: sequencer of the pair checker
// Steps through trial divisions for both numbers, then hands off the result.
// ----------------------------------------------------------------------------
module apc_ctrl
   import apc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  apc_sts_type sts,
   output apc_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_START  = 5'b00010,
      S_DIV    = 5'b00100,
      S_STEP   = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (!sts.loop_end) begin
               cmd.accum = 1'b1;
               state_in  = S_START;
            end else if (!sts.last_number) begin
               cmd.next_number = 1'b1;
               state_in        = S_START;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // Hold until the result register is free.
            if (!sts.out_full) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/amicable_pair_check.sv]
// ----------------------------------------------------------------------------
// amicable_pair_check: amicable number pair test
// Sums the proper divisors of two numbers and flags an amicable pair.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    req_payload_type (two numbers)
//   rsp_      out         rsp_valid/rsp_ready    rsp_payload_type (flag, two sums)
//
// Work: one request at a time. Each number n takes floor(sqrt(n)) + 1 trial
//   divisions (one for n = 0); each trial runs a launch, the one-bit-per-cycle
//   divider (DATA_WIDTH steps), done and accumulate. A request of two 16-bit
//   numbers takes at most 512 trials.
// Reset: synchronous, active high; returns to idle with no result pending.
// Stalls: the result register parts the two sides, so a new request is taken
//   while a finished result waits; a result stalled on rsp_ready holds the
//   next one in its final step.
//
module amicable_pair_check
   import apc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   apc_cmd_type cmd;
   apc_sts_type sts;

   // Sequence the trial divisions over both numbers.
   apc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Divide, accumulate divisor pairs, drive the result register.
   apc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[hw/rtl/apc_checker.sv]
// ----------------------------------------------------------------------------
// apc_checker: port-level checks for the amicable pair checker
// Watches handshakes on both channels; attached to the top level by bind.
// ----------------------------------------------------------------------------
module apc_checker
   import apc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // A waiting request holds its value.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("request dropped or changed while waiting");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped or changed while stalled");

   // Drop any pending result on reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Accept one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // A result never appears in the cycle after its request is taken.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("result appeared before any division ran");

endmodule

bind amicable_pair_check apc_checker u_apc_checker (.*);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for amicable_pair_check
// Drives pairs of numbers through the request channel, predicts the two
// proper divisor sums and the amicable flag unless typed in, and compares every
// response field by field in order. A short table of directed pairs comes
// first, then constrained-by-hand random pairs with random stalls on both
// sides, one long response hold-off and a full drain of the block between the two.
// ----------------------------------------------------------------------------
module testbench;
   import apc_pkg::*;

   localparam int     CLOCK_PERIOD     = 20;
   localparam int     RESET_CYCLES     = 6;
   localparam int     RANDOM_ITEMS     = 76;
   // Final stretch of random requests that runs with no stalls at all.
   localparam int     STEADY_ITEMS     = 20;
   // Longer than two worst-case requests, so the result
   // register and the datapath both fill and req_ready drops.
   localparam int     LONG_HOLD_CYCLES = 40000;
   localparam int     SETTLE_CYCLES    = 100;
   // Covers 100 worst-case requests plus stalls with a wide margin.
   localparam longint TIMEOUT_CYCLES   = 6_000_000;

   typedef struct {
      req_payload_type item;
      bit              answer_given;
      rsp_payload_type answer;
   } stimulus_row_type;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;

   rsp_payload_type  expected_results[$];
   stimulus_row_type directed_rows[$];
   int unsigned      mismatch_count  = 0;
   bit               steady          = 1'b0;  // no stalls on either side
   bit               long_hold_due   = 1'b0;  // ask the receiver for one long hold-off

   amicable_pair_check i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever begin
         #(CLOCK_PERIOD / 2) clock = ~clock;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Sum every divisor below n by walking divisor pairs (d, n/d) up to sqrt(n).
   function automatic longint unsigned proper_divisor_total(input longint unsigned n);
      longint unsigned total;
      longint unsigned d;
      longint unsigned partner;
      total = 0;
      if (n >= 2) begin
         for (d = 1; d * d <= n; d++) begin
            if (n % d == 0) begin
               partner = n / d;
               if (d != n) total += d;
               if (partner != d && partner != n) total += partner;
            end
         end
      end
      return total;
   endfunction

   // Compare on the exact sums; saturate only what is reported.
   function automatic rsp_payload_type amicable_verdict(input req_payload_type item);
      longint unsigned mask;
      longint unsigned a;
      longint unsigned b;
      longint unsigned sum_a;
      longint unsigned sum_b;
      rsp_payload_type verdict;
      mask  = (64'd1 << DATA_WIDTH) - 1;
      a     = item.first_number & mask;
      b     = item.second_number & mask;
      sum_a = proper_divisor_total(a);
      sum_b = proper_divisor_total(b);
      verdict.is_amicable        = (sum_a == b) && (sum_b == a);
      verdict.first_divisor_sum  = SUM_WIDTH'((sum_a > SUM_MAX) ? SUM_MAX : sum_a);
      verdict.second_divisor_sum = SUM_WIDTH'((sum_b > SUM_MAX) ? SUM_MAX : sum_b);
      return verdict;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus sources
   // ------------------------------------------------------------------------

   // Every amicable pair that fits in 16 bits.
   function automatic logic [FIELD_WIDTH-1:0] amicable_member(input int unsigned pair,
                                                              input bit upper);
      case (pair)
         0:       return upper ? 16'd284   : 16'd220;
         1:       return upper ? 16'd1210  : 16'd1184;
         2:       return upper ? 16'd2924  : 16'd2620;
         3:       return upper ? 16'd5564  : 16'd5020;
         4:       return upper ? 16'd6368  : 16'd6232;
         5:       return upper ? 16'd10856 : 16'd10744;
         6:       return upper ? 16'd14595 : 16'd12285;
         default: return upper ? 16'd18416 : 16'd17296;
      endcase
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] perfect_number(input int unsigned pick);
      case (pick)
         0:       return 16'd6;
         1:       return 16'd28;
         2:       return 16'd496;
         default: return 16'd8128;
      endcase
   endfunction

   // Many real pairs (amicable, perfect with itself) so the flag fires
   // often; the rest are near misses, small numbers and full-range noise.
   function automatic req_payload_type random_request();
      req_payload_type item;
      logic [FIELD_WIDTH-1:0] spare;
      int unsigned kind;
      int unsigned pick;
      kind = $urandom_range(0, 9);
      pick = $urandom_range(0, 7);
      case (kind)
         0, 1, 2: begin
            item.first_number  = amicable_member(pick, 1'b0);
            item.second_number = amicable_member(pick, 1'b1);
         end
         3: begin
            item.first_number  = perfect_number(pick % 4);
            item.second_number = $urandom_range(0, 1) ? item.first_number
                                                      : perfect_number($urandom_range(0, 3));
         end
         4: begin
            item.first_number  = FIELD_WIDTH'($urandom_range(0, 63));
            item.second_number = FIELD_WIDTH'($urandom_range(0, 63));
         end
         5: begin
            // Break one side of a real pair by a single flipped low bit.
            item.first_number  = amicable_member(pick, 1'b0);
            item.second_number = amicable_member(pick, 1'b1) ^ (16'd1 << $urandom_range(0, 3));
         end
         default: begin
            item.first_number  = FIELD_WIDTH'($urandom_range(0, 65535));
            item.second_number = FIELD_WIDTH'($urandom_range(0, 65535));
         end
      endcase
      if ($urandom_range(0, 1)) begin
         spare              = item.first_number;
         item.first_number  = item.second_number;
         item.second_number = spare;
      end
      return item;
   endfunction

   task automatic add_row(input int unsigned first, input int unsigned second,
                          input bit answer_given, input bit flag = 1'b0,
                          input int unsigned first_sum = 0, input int unsigned second_sum = 0);
      stimulus_row_type row;
      row.item.first_number         = FIELD_WIDTH'(first);
      row.item.second_number        = FIELD_WIDTH'(second);
      row.answer_given              = answer_given;
      row.answer.is_amicable        = flag;
      row.answer.first_divisor_sum  = SUM_WIDTH'(first_sum);
      row.answer.second_divisor_sum = SUM_WIDTH'(second_sum);
      directed_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   // Offer one request, with an optional random gap first, and hold it until
   // the block takes it. Called and returning at a rising edge.
   task automatic offer(input req_payload_type item, input rsp_payload_type answer);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(answer);
   endtask

   initial begin
      stimulus_row_type row;
      req_payload_type  item;
      int unsigned      i;

      // Directed table: answers typed in where they are plain to see.
      add_row(0,     0,     1, 1'b1, 0,     0);      // zero pairs with zero
      add_row(1,     1,     1, 1'b0, 0,     0);
      add_row(0,     1,     1, 1'b0, 0,     0);
      add_row(1,     0,     1, 1'b0, 0,     0);
      add_row(220,   284,   1, 1'b1, 284,   220);
      add_row(284,   220,   1, 1'b1, 220,   284);
      add_row(6,     6,     1, 1'b1, 6,     6);      // perfect number with itself
      add_row(28,    28,    1, 1'b1, 28,    28);
      add_row(6,     28,    1, 1'b0, 6,     28);
      add_row(496,   8128,  1, 1'b0, 496,   8128);
      add_row(1184,  1210,  1, 1'b1, 1210,  1184);
      add_row(12285, 14595, 1, 1'b1, 14595, 12285);  // odd pair
      add_row(17296, 18416, 1, 1'b1, 18416, 17296);  // largest 16-bit pair
      add_row(2,     3,     1, 1'b0, 1,     1);
      add_row(65521, 65521, 1, 1'b0, 1,     1);      // largest 16-bit prime
      add_row(32768, 32768, 1, 1'b0, 32767, 32767);
      add_row(65535, 65535, 0);
      add_row(65535, 0,     0);
      add_row(0,     65535, 0);
      add_row(16'hAAAA, 16'h5555, 0);
      add_row(16'h5555, 16'hAAAA, 0);
      add_row(220,   285,   0);                      // near miss
      add_row(49,    25,    0);                      // perfect squares
      add_row(55440, 1,     0);                      // very large divisor sum

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         offer(row.item, row.answer_given ? row.answer : amicable_verdict(row.item));
      end

      // Drop valid and let the block drain completely before going random.
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);

      // Keep offering while the receiver sits on its long hold-off.
      long_hold_due = 1'b1;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - STEADY_ITEMS) steady = 1'b1;
         item = random_request();
         offer(item, amicable_verdict(item));
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      // Give any stray response a chance to show up.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: random back-pressure plus one long hold-off
   // ------------------------------------------------------------------------
   initial begin
      int unsigned span;
      @(posedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         span = steady ? 1 : $urandom_range(1, 20);
         repeat (span) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Response checker: each taken response against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, actual %p", $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.is_amicable !== want.is_amicable) begin
               $display("%0t: is_amicable expected %0d actual %0d",
                        $time, want.is_amicable, rsp_payload.is_amicable);
               mismatch_count++;
            end
            if (rsp_payload.first_divisor_sum !== want.first_divisor_sum) begin
               $display("%0t: first_divisor_sum expected %0d actual %0d",
                        $time, want.first_divisor_sum, rsp_payload.first_divisor_sum);
               mismatch_count++;
            end
            if (rsp_payload.second_divisor_sum !== want.second_divisor_sum) begin
               $display("%0t: second_divisor_sum expected %0d actual %0d",
                        $time, want.second_divisor_sum, rsp_payload.second_divisor_sum);
               mismatch_count++;
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Mismatches found");
      $finish;
   end

endmodule
